FILE: src/h264rl_pkg.sv
// Shared types and constants of the H.264 reference list builder.
// No dependencies; used by h264rl_sort and h264_ref_list_builder_unit.
`default_nettype none
package h264rl_pkg;
   localparam int STORE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int LIST_LIMIT  = 16;
   localparam int LIM_W       = 5;
   localparam int KEY_W       = 33;

   localparam logic [1:0] KIND_IDR = 2'd0;
   localparam logic [1:0] KIND_I   = 2'd1;
   localparam logic [1:0] KIND_P   = 2'd2;
   localparam logic [1:0] KIND_B   = 2'd3;

   localparam logic [2:0] CSR_MAX_L0_P   = 3'd0;
   localparam logic [2:0] CSR_MAX_L0_B   = 3'd1;
   localparam logic [2:0] CSR_MAX_L1_B   = 3'd2;
   localparam logic [2:0] CSR_CAPACITY   = 3'd3;
   localparam logic [2:0] CSR_INTER_EN   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [31:0]       poc;
      logic [31:0]       dnum;
   } entry_type;

   function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] v);
      logic [LIM_W-1:0] r;
      r = (v > LIM_W'(LIST_LIMIT)) ? LIM_W'(LIST_LIMIT) : v;
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: src/h264rl_sort.sv
// Sorted row of insertion cells holding the candidate reference frames.
// Depends on h264rl_pkg.
`default_nettype none
module h264rl_sort
   import h264rl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              insert,
   input  wire logic [KEY_W-1:0]  in_key,
   input  wire entry_type         in_entry,
   input  wire logic [SLOT_W-1:0] rd_idx,
   output entry_type              rd_entry
);
   logic [KEY_W-1:0] key_ff   [STORE_DEPTH];
   entry_type        ent_ff   [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] vld_ff;
   logic [STORE_DEPTH-1:0] gt;

   // A cell moves when its key is above the new one (stable on ties).
   always_comb begin
      for (int p = 0; p < STORE_DEPTH; p++) begin
         gt[p] = !vld_ff[p] || (key_ff[p] > in_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (insert) begin
         vld_ff <= {vld_ff[STORE_DEPTH-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         for (int p = 0; p < STORE_DEPTH; p++) begin
            if (gt[p]) begin
               if (p == 0 || !gt[(p == 0) ? 0 : p-1]) begin
                  key_ff[p] <= in_key;
                  ent_ff[p] <= in_entry;
               end else begin
                  key_ff[p] <= key_ff[(p == 0) ? 0 : p-1];
                  ent_ff[p] <= ent_ff[(p == 0) ? 0 : p-1];
               end
            end
         end
      end
   end

   assign rd_entry = ent_ff[rd_idx];
endmodule
`default_nettype wire

FILE: src/h264_ref_list_builder_unit.sv
// Top level of the H.264 default reference list builder.
// Depends on h264rl_pkg and h264rl_sort.
`default_nettype none
// One request word per frame to encode. The reference store is a 16-entry
// circular memory (newest at the head) with one synchronous read port. A
// frame is accepted, then the store is read into the sorting cells, one
// memory read per cycle; the list words are then emitted, one per cycle while
// the response side is ready (a single word for an empty run); last, the frame
// is pushed into the store unless it is a B frame or inter_en is clear.
// No new frame is accepted until the push state is done.
// Responses come as a run ended by tlast; an IDR or I frame, an empty store
// or zero limits give one word with entry_valid low. The store needs no
// clearing pass after reset.
module h264_ref_list_builder_unit
   import h264rl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] frame_kind, [33:2] order_count, [65:34] decode_number, rest zero
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] slot_index, [35:4] ref_order_count, [67:36] ref_decode_number
   output logic [71:0]      rsp_tdata,
   // [0] list_select, [1] entry_valid
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);
   // configuration
   logic [LIM_W-1:0] max_p_ff, max_l0b_ff, max_l1b_ff, cap_ff;
   logic             inter_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_p_ff    <= LIM_W'(1);
         max_l0b_ff  <= LIM_W'(1);
         max_l1b_ff  <= LIM_W'(1);
         cap_ff      <= LIM_W'(16);
         inter_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_L0_P: max_p_ff    <= csr_wdata;
            CSR_MAX_L0_B: max_l0b_ff  <= csr_wdata;
            CSR_MAX_L1_B: max_l1b_ff  <= csr_wdata;
            CSR_CAPACITY: cap_ff      <= csr_wdata;
            CSR_INTER_EN: inter_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // state machine
   state_type state_ff, state_in;
   logic req_acc, issue, load_done, emit_adv, emit_end;

   // current frame
   logic [1:0]       kind_ff;
   logic [31:0]      poc_ff, dnum_ff;
   logic [LIM_W-1:0] lim0_ff, lim1_ff;

   // store
   logic [63:0]       mem [STORE_DEPTH];
   logic [63:0]       mem_q;
   logic [SLOT_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] new_head;

   // load and sort
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              rd_pend_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic [CNT_W-1:0]  n_ff, np_ff;
   logic              is_fut;
   logic [KEY_W-1:0]  ins_key;
   entry_type         ins_entry, rd_entry;
   logic [SLOT_W-1:0] sel_idx;

   // emit
   logic              phase_ff;
   logic [CNT_W-1:0]  j_ff;
   logic [CNT_W-1:0]  e0, e1, l1_pos;
   logic              empty_run, word_last;
   logic              sort_clear;

   assign req_acc   = req_tvalid && req_tready;
   assign issue     = (state_ff == ST_LOAD) && (rd_idx_ff < count_ff);
   assign load_done = (state_ff == ST_LOAD) && !issue && !rd_pend_ff;
   assign emit_adv  = (state_ff == ST_EMIT) && (!rsp_tvalid || rsp_tready);

   assign e0 = (n_ff < CNT_W'(lim0_ff)) ? n_ff : CNT_W'(lim0_ff);
   assign e1 = (n_ff < CNT_W'(lim1_ff)) ? n_ff : CNT_W'(lim1_ff);
   assign empty_run = (e0 == '0) && (e1 == '0);

   // list 1 is the same sorted row rotated to start at the future group
   always_comb begin
      l1_pos = np_ff + j_ff;
      if (l1_pos >= n_ff) begin
         l1_pos = l1_pos - n_ff;
      end
   end
   assign sel_idx = phase_ff ? l1_pos[SLOT_W-1:0] : j_ff[SLOT_W-1:0];

   always_comb begin
      if (empty_run) begin
         word_last = 1'b1;
      end else if (!phase_ff) begin
         word_last = (j_ff == e0 - 1'b1) && (e1 == '0);
      end else begin
         word_last = (j_ff == e1 - 1'b1);
      end
   end
   assign emit_end = emit_adv && word_last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc)   state_in = ST_LOAD;
         ST_LOAD: if (load_done) state_in = ST_EMIT;
         ST_EMIT: if (emit_end)  state_in = ST_PUSH;
         ST_PUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready = 1'b0;
      sort_clear = 1'b0;
      mem_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            sort_clear = 1'b1;
         end
         ST_LOAD: ;
         ST_EMIT: ;
         ST_PUSH: mem_we = (kind_ff != KIND_B) && inter_en_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the frame and its list limits
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff <= req_tdata[1:0];
         poc_ff  <= req_tdata[33:2];
         dnum_ff <= req_tdata[65:34];
         unique case (req_tdata[1:0])
            KIND_P: begin
               lim0_ff <= clamp_limit(max_p_ff);
               lim1_ff <= '0;
            end
            KIND_B: begin
               lim0_ff <= clamp_limit(max_l0b_ff);
               lim1_ff <= clamp_limit(max_l1b_ff);
            end
            KIND_IDR, KIND_I: begin
               lim0_ff <= '0;
               lim1_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // store memory: one write and one registered read per cycle
   assign new_head = head_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[new_head] <= {poc_ff, dnum_ff};
      end
      mem_q <= mem[head_ff + rd_idx_ff[SLOT_W-1:0]];
   end

   // store bookkeeping: an IDR frame empties it; else drop the oldest down to capacity, push at the head
   logic [CNT_W-1:0] cap_eff, cnt_kept;
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(cap_ff) > CNT_W'(STORE_DEPTH)) begin
         cap_eff = CNT_W'(STORE_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
      cnt_kept = (count_ff >= cap_eff) ? cap_eff - 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (req_acc && req_tdata[1:0] == KIND_IDR) begin
         count_ff <= '0;
      end else if (mem_we) begin
         head_ff  <= new_head;
         count_ff <= cnt_kept + 1'b1;
      end
   end

   // read the store one slot per cycle into the sorting cells
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         if (req_acc) begin
            rd_idx_ff <= '0;
         end else if (issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
      rd_slot_ff <= rd_idx_ff[SLOT_W-1:0];
   end

   // past frames by falling count, then future by rising; P keeps store order
   assign is_fut  = (kind_ff == KIND_B) && (mem_q[63:32] > poc_ff);
   always_comb begin
      if (kind_ff != KIND_B) begin
         ins_key = '0;
      end else if (is_fut) begin
         ins_key = {1'b1, mem_q[63:32]};
      end else begin
         ins_key = {1'b0, ~mem_q[63:32]};
      end
   end
   assign ins_entry.slot = rd_slot_ff;
   assign ins_entry.poc  = mem_q[63:32];
   assign ins_entry.dnum = mem_q[31:0];

   always_ff @(posedge clock) begin
      if (reset || sort_clear) begin
         n_ff  <= '0;
         np_ff <= '0;
      end else if (rd_pend_ff) begin
         n_ff <= n_ff + 1'b1;
         if (!is_fut) begin
            np_ff <= np_ff + 1'b1;
         end
      end
   end

   h264rl_sort u_sort (
      .clock    (clock),
      .reset    (reset),
      .clear    (sort_clear),
      .insert   (rd_pend_ff),
      .in_key   (ins_key),
      .in_entry (ins_entry),
      .rd_idx   (sel_idx),
      .rd_entry (rd_entry)
   );

   // walk list 0 then list 1, one word per cycle while the response side is ready
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         j_ff     <= '0;
      end else if (load_done) begin
         phase_ff <= (e0 == '0);
         j_ff     <= '0;
      end else if (emit_adv && !empty_run) begin
         if (!phase_ff && j_ff == e0 - 1'b1) begin
            phase_ff <= 1'b1;
            j_ff     <= '0;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   // output register: hold until taken
   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_adv) begin
         rsp_last_ff <= word_last;
         if (empty_run) begin
            rsp_data_ff <= '0;
            rsp_user_ff <= '0;
         end else begin
            rsp_data_ff <= {4'd0, rd_entry.dnum, rd_entry.poc, 4'(rd_entry.slot)};
            rsp_user_ff <= {1'b1, phase_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("store count above depth");
   a_entry_needs_cells: assert property (@(posedge clock) disable iff (reset)
      (emit_adv && !empty_run) |-> (n_ff != '0))
      else $error("list entry emitted from an empty cell row");
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_LOAD && !req_tready))
      else $error("frame accepted while busy");
   a_push_at_end: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> $past(state_ff == ST_EMIT))
      else $error("store written outside the frame end");
`endif
endmodule
`default_nettype wire
